// ===== src/csdm_pkg.sv =====
// package: constants, types and float helpers for the sparse-dense multiply
package csdm_pkg;

    localparam int InnerDim = 1024;
    localparam int OutCols = 32;
    localparam int RowW = 10;
    localparam int ColW = 5;
    localparam int AddrW = RowW + ColW;
    localparam logic [31:0] CanonNan = 32'h7FC00000;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ACC    = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    // float multiply, round to nearest even, ieee single with subnormals
    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic sa;
        logic sb;
        logic sr;
        logic [7:0] ea;
        logic [7:0] eb;
        logic [22:0] fa;
        logic [22:0] fb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [47:0] p;
        logic signed [10:0] e;
        logic [5:0] lz;
        logic [47:0] n;
        logic [49:0] s;
        logic [24:0] m;
        logic g;
        logic st;
        logic [31:0] r;
        int i;
        sa = a[31]; sb = b[31]; sr = sa ^ sb;
        ea = a[30:23]; eb = b[30:23]; fa = a[22:0]; fb = b[22:0];
        r = '0;
        if ((ea == 8'hFF && fa != 0) || (eb == 8'hFF && fb != 0)) begin
            r = CanonNan;
        end else if (ea == 8'hFF || eb == 8'hFF) begin
            if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0)) r = CanonNan;
            else r = {sr, 8'hFF, 23'd0};
        end else if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0)) begin
            r = {sr, 31'd0};
        end else begin
            ma = {(ea != 0), fa};
            mb = {(eb != 0), fb};
            p = ma * mb;
            // value = p * 2^(e-127-47) with e = ea+eb-126 form below
            e = $signed({3'd0, (ea == 0) ? 8'd1 : ea}) +
                $signed({3'd0, (eb == 0) ? 8'd1 : eb}) - 11'sd126;
            lz = '0;
            for (i = 47; i >= 0; i--) begin
                if (p[i]) begin
                    lz = 6'(47 - i);
                    break;
                end
            end
            n = p << lz;
            e = e - $signed({5'd0, lz});
            // n[47] at exponent e; subnormal shift
            s = {n, 2'b00};
            if (e < 11'sd1) begin
                if (e < -11'sd48) s = {49'd0, 1'b1};
                else s = ({n, 2'b00} >> (11'sd1 - e)) |
                         {49'd0, |({n, 2'b00} & ~({50{1'b1}} << (11'sd1 - e)))};
                e = 11'sd0;
            end
            m = {1'b0, s[49:26]};
            g = s[25];
            st = |s[24:0];
            if (g && (st || m[0])) m = m + 25'd1;
            if (e == 0) begin
                if (m[23]) e = 11'sd1;
            end else if (m[24]) begin
                m = m >> 1;
                e = e + 11'sd1;
            end
            if (e >= 11'sd255) r = {sr, 8'hFF, 23'd0};
            else r = {sr, e[7:0], m[22:0]};
        end
        return r;
    endfunction

    // float add, round to nearest even
    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic [7:0] ea;
        logic [7:0] eb;
        logic [22:0] fa;
        logic [22:0] fb;
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0] ex;
        logic [7:0] ey;
        logic [8:0] d;
        logic [27:0] mx;
        logic [27:0] my;
        logic [27:0] sh;
        logic [28:0] sm;
        logic signed [10:0] e;
        logic [4:0] lz;
        logic [28:0] n;
        logic [24:0] m;
        logic g;
        logic st;
        logic sr;
        logic [31:0] r;
        int i;
        ea = a[30:23]; eb = b[30:23]; fa = a[22:0]; fb = b[22:0];
        r = '0;
        if ((ea == 8'hFF && fa != 0) || (eb == 8'hFF && fb != 0)) begin
            r = CanonNan;
        end else if (ea == 8'hFF && eb == 8'hFF) begin
            r = (a[31] != b[31]) ? CanonNan : a;
        end else if (ea == 8'hFF) begin
            r = a;
        end else if (eb == 8'hFF) begin
            r = b;
        end else begin
            if (a[30:0] >= b[30:0]) begin x = a; y = b; end
            else begin x = b; y = a; end
            ex = (x[30:23] == 0) ? 8'd1 : x[30:23];
            ey = (y[30:23] == 0) ? 8'd1 : y[30:23];
            // 1 hidden + 23 frac + 3 guard bits, one spare on top
            mx = {1'b0, (x[30:23] != 0), x[22:0], 3'd0};
            my = {1'b0, (y[30:23] != 0), y[22:0], 3'd0};
            d = {1'b0, ex} - {1'b0, ey};
            if (d > 9'd27) sh = {27'd0, |my};
            else sh = (my >> d) | {27'd0, |(my & ~({28{1'b1}} << d))};
            if (x[31] == y[31]) sm = {1'b0, mx} + {1'b0, sh};
            else sm = {1'b0, mx} - {1'b0, sh};
            sr = x[31];
            if (sm == 0) begin
                r = {a[31] & b[31], 31'd0};
            end else begin
                e = $signed({3'd0, ex}) + 11'sd1;
                // sm bit 27 at exponent e
                lz = '0;
                for (i = 28; i >= 0; i--) begin
                    if (sm[i]) begin
                        lz = 5'(28 - i);
                        break;
                    end
                end
                n = sm;
                if (lz == 0) begin
                    n = (sm >> 1) | {28'd0, sm[0]};
                    e = e + 11'sd1;
                end else if ($signed({6'd0, lz}) - 11'sd1 < e) begin
                    n = sm << (lz - 5'd1);
                    e = e - $signed({6'd0, lz}) + 11'sd1;
                end else begin
                    n = sm << (e[4:0] - 5'd1);
                    e = 11'sd0;
                end
                // n[27] is hidden bit at exponent e (0 means subnormal)
                m = {1'b0, n[27:4]};
                g = n[3];
                st = |n[2:0];
                if (g && (st || m[0])) m = m + 25'd1;
                if (e == 0) begin
                    if (m[23]) e = 11'sd1;
                end else if (m[24]) begin
                    m = m >> 1;
                    e = e + 11'sd1;
                end
                if (e >= 11'sd255) r = {sr, 8'hFF, 23'd0};
                else r = {sr, e[7:0], m[22:0]};
            end
        end
        return r;
    endfunction

endpackage

// ===== src/csr_sparse_dense_matmul.sv =====
// top level: sparse row times dense matrix, one multiply-add per cycle
// a load writes the dense store and stays idle; a nonzero runs its 32 columns through one
// shared multiply-add, with dense store read and product register in the pipe, before the next input
// a finish emits 32 results, one per cycle as the sink takes them, then clears the
// accumulator row in the CLEAR state; reset clears the row at once; dense store has no reset
module csr_sparse_dense_matmul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [9:0]  inner_index,
    input  logic [4:0]  lane,
    input  logic [31:0] value_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  out_column,
    output logic [31:0] out_value,
    output logic        row_done
);
    logic [31:0] dense_mem [csdm_pkg::InnerDim * csdm_pkg::OutCols];
    logic [31:0] acc_mem [csdm_pkg::OutCols];
    logic [csdm_pkg::OutCols-1:0] acc_ok_reg;

    csdm_pkg::state_t state_reg, state_next;
    logic [csdm_pkg::RowW-1:0] row_reg;
    logic [31:0] val_reg;
    logic [5:0] cnt_reg, cnt_next;
    logic [31:0] rd_reg;
    logic rd_v_reg;
    logic [4:0] rd_c_reg;
    logic prod_v_reg;
    logic [4:0] prod_c_reg;
    logic [31:0] acc_q_reg;
    logic [31:0] emit_rd_reg;
    logic [31:0] sum;
    logic [31:0] acc_rd;
    logic in_fire;
    logic out_fire;
    logic issue;

    assign in_fire = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready = (state_reg == csdm_pkg::ST_IDLE);
    assign issue = (state_reg == csdm_pkg::ST_ACC) && !cnt_reg[5];

    always_ff @(posedge clk)
    begin
        if (in_fire && op == csdm_pkg::OP_LOAD)
        begin
            dense_mem[{inner_index, lane}] <= value_bits;
        end
        rd_reg <= dense_mem[{row_reg, cnt_reg[4:0]}];
        if (in_fire)
        begin
            row_reg <= inner_index;
            val_reg <= value_bits;
        end
    end

    // accumulator read registered in the cycle before the add; the write in the same cycle is
    // always the previous column, so no forwarding is needed
    // emit port follows the next column so the result is ready when the state gets there
    always_ff @(posedge clk)
    begin
        if (prod_v_reg)
        begin
            acc_mem[prod_c_reg] <= sum;
        end
        acc_q_reg <= acc_mem[rd_c_reg];
        emit_rd_reg <= acc_mem[cnt_next[4:0]];
    end

    // accumulator entries not yet valid read as positive zero
    assign acc_rd = acc_ok_reg[prod_c_reg] ? acc_q_reg : 32'd0;

    csdm_mac u_mac (
        .clk  (clk),
        .a    (val_reg),
        .b    (rd_reg),
        .acc  (acc_rd),
        .sum  (sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= csdm_pkg::ST_IDLE;
            cnt_reg    <= '0;
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
            acc_ok_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_v_reg   <= issue;
            prod_v_reg <= rd_v_reg;
            if (prod_v_reg) acc_ok_reg[prod_c_reg] <= 1'b1;
            if (state_reg == csdm_pkg::ST_CLEAR) acc_ok_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_c_reg <= cnt_reg[4:0];
        prod_c_reg <= rd_c_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            csdm_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_fire && op == csdm_pkg::OP_ACC) state_next = csdm_pkg::ST_ACC;
                if (in_fire && op == csdm_pkg::OP_FINISH) state_next = csdm_pkg::ST_EMIT;
            end
            csdm_pkg::ST_ACC:
            begin
                // drain: stay until the last column has passed the read and product registers
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd33) state_next = csdm_pkg::ST_IDLE;
            end
            csdm_pkg::ST_EMIT:
            begin
                if (out_fire)
                begin
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'(csdm_pkg::OutCols - 1)) state_next = csdm_pkg::ST_CLEAR;
                end
            end
            csdm_pkg::ST_CLEAR:
            begin
                state_next = csdm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = csdm_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = (state_reg == csdm_pkg::ST_EMIT);
    assign out_column = cnt_reg[4:0];
    assign out_value = acc_ok_reg[cnt_reg[4:0]] ?
        ((emit_rd_reg[30:23] == 8'hFF && emit_rd_reg[22:0] != 0) ?
         csdm_pkg::CanonNan : emit_rd_reg) : 32'd0;
    assign row_done = (cnt_reg[4:0] == 5'(csdm_pkg::OutCols - 1));

    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != csdm_pkg::ST_IDLE |-> !in_ready)
        else $error("input taken while busy");
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && row_done |=> state_reg == csdm_pkg::ST_CLEAR)
        else $error("row not cleared after last result");
    a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == csdm_pkg::ST_EMIT |-> !prod_v_reg && !rd_v_reg)
        else $error("emit while accumulating");
endmodule

// ===== src/csdm_mac.sv =====
// shared multiply then add, one register between them
module csdm_mac (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] acc,
    output logic [31:0] sum
);
    logic [31:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= csdm_pkg::fmul(a, b);
    end

    assign sum = csdm_pkg::fadd(acc, prod_reg);
endmodule
